// ===== sv/rnp_pkg.sv =====
// ============================================================================
// Radix numeral parse package
// Shared widths, character codes, error codes, types and the character
// decoder used by the parser, the emitter and the top level.
// ============================================================================
package rnp_pkg;

    localparam int MAX_DIGITS = 64;
    localparam int ADDR_W     = $clog2(MAX_DIGITS);
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
    localparam int DIGIT_W    = 6;
    localparam int ERR_W      = 4;
    localparam int RADIX_W    = 6;
    localparam int CHAR_W     = 8;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic               REG_RADIX   = 1'b0;

    // Character codes.
    localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_POINT  = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_OPEN   = 8'h28;
    localparam logic [CHAR_W-1:0] CH_CLOSE  = 8'h29;
    localparam logic [CHAR_W-1:0] CH_0      = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9      = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_Z   = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LO_A   = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_Z   = 8'h7A;

    // Error codes.
    localparam logic [ERR_W-1:0] ERR_NONE        = 4'd0;
    localparam logic [ERR_W-1:0] ERR_SIGN        = 4'd1;
    localparam logic [ERR_W-1:0] ERR_TWO_POINTS  = 4'd2;
    localparam logic [ERR_W-1:0] ERR_NO_INT      = 4'd3;
    localparam logic [ERR_W-1:0] ERR_NESTED      = 4'd4;
    localparam logic [ERR_W-1:0] ERR_RPT_EARLY   = 4'd5;
    localparam logic [ERR_W-1:0] ERR_STRAY_CLOSE = 4'd6;
    localparam logic [ERR_W-1:0] ERR_EMPTY_RPT   = 4'd7;
    localparam logic [ERR_W-1:0] ERR_BAD_CHAR    = 4'd8;
    localparam logic [ERR_W-1:0] ERR_UNCLOSED    = 4'd9;
    localparam logic [ERR_W-1:0] ERR_NO_FRAC     = 4'd10;
    localparam logic [ERR_W-1:0] ERR_NO_DIGITS   = 4'd11;
    localparam logic [ERR_W-1:0] ERR_TOO_LONG    = 4'd12;

    // Parse state of one numeral, also handed to the emitter as a summary.
    typedef struct packed {
        logic [ERR_W-1:0]  err;
        logic              sign;
        logic              point;
        logic              paren;
        logic [CNT_W-1:0]  count;
        logic [CNT_W-1:0]  frac;
        logic [CNT_W-1:0]  rep;
        logic [CNT_W-1:0]  grp;
        logic              int_nz;
        logic [ADDR_W-1:0] first_nz;
        logic              frac_nz;
        logic [ADDR_W-1:0] last_nz;
    } t_parse_sum;

    localparam t_parse_sum PARSE_CLEAR = '0;

    typedef struct packed {
        logic               ok;
        logic [DIGIT_W-1:0] val;
    } t_char_val;

    typedef struct packed {
        logic [DIGIT_W-1:0] digit_value;
        logic               negative;
        logic               in_fraction;
        logic               in_repeat;
        logic [ERR_W-1:0]   error_code;
        logic               last_result;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC1,
        ST_CALC2,
        ST_EMIT_RD,
        ST_EMIT_LD
    } t_state;

    function automatic t_char_val char_value(input logic [CHAR_W-1:0] c);
        t_char_val r;
        r.ok  = 1'b1;
        r.val = '0;
        if (c inside {[CH_0:CH_9]}) begin
            r.val = DIGIT_W'(c - CH_0);
        end else if (c inside {[CH_UP_A:CH_UP_Z]}) begin
            r.val = DIGIT_W'(c - CH_UP_A + 8'd10);
        end else if (c inside {[CH_LO_A:CH_LO_Z]}) begin
            r.val = DIGIT_W'(c - CH_LO_A + 8'd10);
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

endpackage

// ===== sv/rnp_ram.sv =====
// ============================================================================
// Generic simple dual-port RAM
// One write port and one read port with a registered, enabled read.
// ============================================================================
module rnp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/rnp_parser.sv =====
// ============================================================================
// Numeral character parser
// Checks the syntax one character per beat, writes digit values to the
// digit store and tracks the counts and zero-trim positions of the numeral.
// ============================================================================
module rnp_parser
    import rnp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic [CHAR_W-1:0]   i_char_code,
    input  logic                i_is_final,
    input  logic [RADIX_W-1:0]  i_radix,
    output logic                o_we,
    output logic [ADDR_W-1:0]   o_waddr,
    output logic [DIGIT_W-1:0]  o_wdata,
    output t_parse_sum          o_sum
);

    t_parse_sum r_st;
    t_parse_sum n_st;
    t_parse_sum upd;
    logic       r_first_pending;
    logic       n_first_pending;
    t_char_val  cv;

    assign cv = char_value(i_char_code);

    always_comb begin
        upd     = r_st;
        o_we    = 1'b0;
        o_waddr = r_st.count[ADDR_W-1:0];
        o_wdata = cv.val;
        if (i_fire && r_st.err == ERR_NONE) begin
            case (i_char_code)
                CH_MINUS: begin
                    if (!r_first_pending) upd.err = ERR_SIGN;
                    else upd.sign = 1'b1;
                end
                CH_POINT: begin
                    if (r_st.point) upd.err = ERR_TWO_POINTS;
                    else if (r_st.count == '0) upd.err = ERR_NO_INT;
                    else upd.point = 1'b1;
                end
                CH_OPEN: begin
                    if (r_st.paren) upd.err = ERR_NESTED;
                    else if (!r_st.point) upd.err = ERR_RPT_EARLY;
                    else begin
                        upd.paren = 1'b1;
                        upd.grp   = '0;
                    end
                end
                CH_CLOSE: begin
                    if (!r_st.paren) upd.err = ERR_STRAY_CLOSE;
                    else if (r_st.grp == '0) upd.err = ERR_EMPTY_RPT;
                    else upd.paren = 1'b0;
                end
                default: begin
                    if (cv.ok && cv.val < i_radix) begin
                        if (r_st.count >= CNT_W'(MAX_DIGITS)) begin
                            upd.err = ERR_TOO_LONG;
                        end else begin
                            o_we      = 1'b1;
                            upd.count = r_st.count + 1'b1;
                            if (r_st.point) upd.frac = r_st.frac + 1'b1;
                            if (r_st.paren) begin
                                upd.rep = r_st.rep + 1'b1;
                                upd.grp = r_st.grp + 1'b1;
                            end
                            // Remember where the kept digits start and end.
                            if (cv.val != '0) begin
                                if (!r_st.point && !r_st.int_nz) begin
                                    upd.int_nz   = 1'b1;
                                    upd.first_nz = r_st.count[ADDR_W-1:0];
                                end
                                if (r_st.point) begin
                                    upd.frac_nz = 1'b1;
                                    upd.last_nz = r_st.count[ADDR_W-1:0];
                                end
                            end
                        end
                    end else begin
                        upd.err = ERR_BAD_CHAR;
                    end
                end
            endcase
        end
    end

    always_comb begin
        n_st            = upd;
        n_first_pending = r_first_pending;
        if (i_fire) begin
            n_first_pending = 1'b0;
            if (i_is_final) begin
                n_st            = PARSE_CLEAR;
                n_first_pending = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st            <= PARSE_CLEAR;
            r_first_pending <= 1'b1;
        end else begin
            r_st            <= n_st;
            r_first_pending <= n_first_pending;
        end
    end

    assign o_sum = upd;

endmodule

// ===== sv/rnp_emitter.sv =====
// ============================================================================
// Normalized digit emitter
// Turns a numeral summary into an error result, a zero result or the trimmed digits,
// reading them from the digit store into the output register.
// ============================================================================
module rnp_emitter
    import rnp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  t_parse_sum          i_sum,
    output logic                o_busy,
    output logic                o_re,
    output logic [ADDR_W-1:0]   o_raddr,
    input  logic [DIGIT_W-1:0]  i_rdata,
    output logic                o_valid,
    input  logic                i_ready,
    output t_result             o_result
);

    t_state r_state;
    t_state n_state;

    t_parse_sum r_sum;

    // First calculation step.
    logic [ERR_W-1:0]  r_err,  n_err;
    logic [CNT_W-1:0]  r_first, n_first;
    logic [CNT_W-1:0]  r_last,  n_last;
    logic [CNT_W-1:0]  r_ipos,  n_ipos;
    logic              r_frac_kept, n_frac_kept;
    logic [CNT_W-1:0]  r_rep;
    logic              r_sign;
    logic              r_int_nz;

    // Second calculation step.
    logic [CNT_W-1:0]  r_n, n_n;
    logic [CNT_W-1:0]  r_fthr, n_fthr;
    logic [CNT_W-1:0]  r_rthr, n_rthr;
    logic              r_zero, n_zero;
    logic [CNT_W-1:0]  c_end;
    logic [CNT_W-1:0]  c_dstart;
    logic [CNT_W-1:0]  c_nrep;

    logic [CNT_W-1:0]  r_k;
    logic              r_out_valid;
    t_result           r_result;

    logic out_free;
    logic single;
    logic is_last;
    logic calc1_en;
    logic calc2_en;
    logic load_single;
    logic load_digit;

    assign out_free = !r_out_valid || i_ready;
    assign single   = (r_err != ERR_NONE) || r_zero;
    assign is_last  = (r_k + 1'b1) == r_n;

    // Step one: final error code and the span of kept digits.
    always_comb begin
        n_err = r_sum.err;
        if (r_sum.err == ERR_NONE) begin
            if (r_sum.paren) n_err = ERR_UNCLOSED;
            else if (r_sum.point && r_sum.frac == '0) n_err = ERR_NO_FRAC;
            else if (r_sum.count == '0) n_err = ERR_NO_DIGITS;
        end
        n_ipos = r_sum.count - r_sum.frac;
        if (r_sum.int_nz) n_first = CNT_W'(r_sum.first_nz);
        else if (r_sum.frac != '0) n_first = n_ipos - 1'b1;
        else n_first = n_ipos;
        n_frac_kept = r_sum.frac != '0;
        n_last      = r_sum.count - 1'b1;
        if (r_sum.frac != '0 && r_sum.rep == '0) begin
            if (r_sum.frac_nz) begin
                n_last = CNT_W'(r_sum.last_nz);
            end else begin
                n_frac_kept = 1'b0;
                n_last      = n_ipos - 1'b1;
            end
        end
    end

    // Step two: digit count and the thresholds of the fraction and tail.
    always_comb begin
        c_end    = r_last + 1'b1;
        n_n      = (c_end > r_first) ? c_end - r_first : '0;
        n_zero   = (n_n == '0) || (n_n == CNT_W'(1) && !r_int_nz);
        c_dstart = r_ipos - r_first;
        c_nrep   = n_n - r_rep;
        n_fthr   = r_frac_kept ? c_dstart : n_n;
        n_rthr   = (r_rep != '0 && c_nrep >= c_dstart) ? c_nrep : n_n;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) n_state = ST_CALC1;
            end
            ST_CALC1: n_state = ST_CALC2;
            ST_CALC2: n_state = ST_EMIT_RD;
            ST_EMIT_RD: begin
                if (!single) n_state = ST_EMIT_LD;
                else if (out_free) n_state = ST_IDLE;
            end
            ST_EMIT_LD: begin
                if (out_free) n_state = is_last ? ST_IDLE : ST_EMIT_RD;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        calc1_en    = 1'b0;
        calc2_en    = 1'b0;
        load_single = 1'b0;
        load_digit  = 1'b0;
        o_re        = 1'b0;
        case (r_state)
            ST_CALC1: calc1_en = 1'b1;
            ST_CALC2: calc2_en = 1'b1;
            ST_EMIT_RD: begin
                if (single) load_single = out_free;
                else o_re = 1'b1;
            end
            ST_EMIT_LD: load_digit = out_free;
            default: ;
        endcase
    end

    assign o_busy  = r_state != ST_IDLE;
    assign o_raddr = ADDR_W'(r_first + r_k);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_single || load_digit) r_out_valid <= 1'b1;
            else if (i_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && r_state == ST_IDLE) r_sum <= i_sum;
        if (calc1_en) begin
            r_err       <= n_err;
            r_first     <= n_first;
            r_last      <= n_last;
            r_ipos      <= n_ipos;
            r_frac_kept <= n_frac_kept;
            r_rep       <= r_sum.rep;
            r_sign      <= r_sum.sign;
            r_int_nz    <= r_sum.int_nz;
        end
        if (calc2_en) begin
            r_n    <= n_n;
            r_fthr <= n_fthr;
            r_rthr <= n_rthr;
            r_zero <= n_zero;
            r_k    <= '0;
        end
        if (load_single) begin
            r_result.digit_value <= '0;
            r_result.negative    <= 1'b0;
            r_result.in_fraction <= 1'b0;
            r_result.in_repeat   <= 1'b0;
            r_result.error_code  <= r_err;
            r_result.last_result <= 1'b1;
        end
        if (load_digit) begin
            r_result.digit_value <= i_rdata;
            r_result.negative    <= r_sign;
            r_result.in_fraction <= r_k >= r_fthr;
            r_result.in_repeat   <= r_k >= r_rthr;
            r_result.error_code  <= ERR_NONE;
            r_result.last_result <= is_last;
            r_k                  <= r_k + 1'b1;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_result;

endmodule

// ===== sv/radix_numeral_parse_normalize_unit.sv =====
// ============================================================================
// Radix numeral parse and normalize unit
// Parses an ASCII numeral in a configurable base and returns its normalized
// digits, or one error code, as a stream of result beats.
// ============================================================================
// The unit takes one character beat per clock cycle while a numeral is being
// parsed: an optional leading minus, digits below the radix register (0-9,
// A-Z or a-z), one radix point and parenthesized repeating groups after the
// point. Digit values go into a 64-entry digit store, a RAM with a registered
// read, and the first syntax error is latched. When the beat marked final
// has been taken the input side stops accepting beats: the calculation states
// CALC1 and CALC2 compute the kept span of digits (leading integer zeros and,
// without a repeat, trailing fraction zeros are trimmed), and then either one
// result beat carries the error code or the zero value, or each kept digit is
// read from the store in a read state and placed in the output register in a
// load state, which waits while the sink is not ready. The input side opens
// again as soon as the final result sits in the output register, so the next
// numeral can start while it waits to be taken. The digit store needs no
// clearing after reset, since only entries written for the current numeral
// are read. The radix register sits at byte address 0 of the APB port,
// resets to 10 and must only be written while the unit is idle.
module radix_numeral_parse_normalize_unit
    import rnp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Character input channel.
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [CHAR_W-1:0]   i_char_code,
    input  logic                i_is_final,
    // Result output channel.
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [DIGIT_W-1:0]  o_digit_value,
    output logic                o_negative,
    output logic                o_in_fraction,
    output logic                o_in_repeat,
    output logic [ERR_W-1:0]    o_error_code,
    output logic                o_last_result,
    // Configuration port.
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    logic [RADIX_W-1:0] r_radix;
    logic               cfg_wr;
    logic               in_fire;
    logic               busy;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [DIGIT_W-1:0] ram_wdata;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [DIGIT_W-1:0] ram_rdata;

    t_parse_sum         sum;
    t_result            result;

    // The register index is the word address; only the radix register exists.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_RADIX);
    assign prdata = (paddr[2] == REG_RADIX) ? APB_DW'(r_radix) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
        end else if (cfg_wr) begin
            r_radix <= pwdata[RADIX_W-1:0];
        end
    end

    // Characters are taken only while no numeral is being emitted, so the
    // store is never written and read for the same numeral at once.
    assign o_in_ready = !busy;
    assign in_fire    = i_in_valid && o_in_ready;

    rnp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (in_fire),
        .i_char_code (i_char_code),
        .i_is_final  (i_is_final),
        .i_radix     (r_radix),
        .o_we        (ram_we),
        .o_waddr     (ram_waddr),
        .o_wdata     (ram_wdata),
        .o_sum       (sum)
    );

    rnp_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (MAX_DIGITS)
    ) u_digit_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    rnp_emitter u_emitter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (in_fire && i_is_final),
        .i_sum    (sum),
        .o_busy   (busy),
        .o_re     (ram_re),
        .o_raddr  (ram_raddr),
        .i_rdata  (ram_rdata),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (result)
    );

    assign o_digit_value = result.digit_value;
    assign o_negative    = result.negative;
    assign o_in_fraction = result.in_fraction;
    assign o_in_repeat   = result.in_repeat;
    assign o_error_code  = result.error_code;
    assign o_last_result = result.last_result;

`ifndef ASSERT_OFF
    // A final character hands the numeral to the emitter, which blocks input.
    a_final_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_is_final) |=> !o_in_ready)
        else $error("input still open after the final character");

    // The store is never written and read in the same cycle.
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> !ram_re)
        else $error("digit store written during emission");

    // An error result is a single beat with a zero digit.
    a_error_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_error_code != ERR_NONE) |->
            (o_last_result && o_digit_value == '0 && !o_negative))
        else $error("malformed error result");
`endif

endmodule

// ===== dv/tb_top.sv =====
// ============================================================================
// Radix numeral parse and normalize unit testbench
// Sends numeral characters under several radix settings, predicts the
// normalized digits or the error code of every numeral, and checks each
// result beat against that prediction.
// ============================================================================
module tb_top
    import rnp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // One character beat as it waits in the backlog of the driver.
    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              fin;
    } t_char_beat;

    localparam logic [APB_AW-1:0] RADIX_ADDR = APB_AW'(4 * REG_RADIX);
    localparam int                DIGIT_NONE = 255;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    logic [CHAR_W-1:0]   i_char_code = '0;
    logic                i_is_final = 1'b0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic [DIGIT_W-1:0]  o_digit_value;
    logic                o_negative;
    logic                o_in_fraction;
    logic                o_in_repeat;
    logic [ERR_W-1:0]    o_error_code;
    logic                o_last_result;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [APB_AW-1:0]   paddr = '0;
    logic [APB_DW-1:0]   pwdata = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    radix_numeral_parse_normalize_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_char_code   (i_char_code),
        .i_is_final    (i_is_final),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_digit_value (o_digit_value),
        .o_negative    (o_negative),
        .o_in_fraction (o_in_fraction),
        .o_in_repeat   (o_in_repeat),
        .o_error_code  (o_error_code),
        .o_last_result (o_last_result),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // 20 ns clock period.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor state. This mirrors what the unit keeps for the numeral that
    // is being parsed, plus our own copy of the radix register.
    // ------------------------------------------------------------------------
    logic [RADIX_W-1:0] cfg_radix = RADIX_RESET;
    logic [DIGIT_W-1:0] digit_mem [MAX_DIGITS];
    logic [CNT_W-1:0]   n_digits;
    logic [CNT_W-1:0]   n_frac;
    logic [CNT_W-1:0]   n_rep;
    logic [CNT_W-1:0]   n_group;
    logic               neg_sign;
    logic               saw_point;
    logic               group_open;
    logic               at_start;
    logic [ERR_W-1:0]   first_err;

    t_result    due_results [$];   // result beats the unit still owes us
    t_char_beat char_backlog [$];  // character beats not yet presented
    int         chars_pushed = 0;
    int         fault_count = 0;

    // Handshake flags captured at the rising edge, read by the drivers at the
    // following falling edge.
    logic in_taken = 1'b0;
    logic out_taken = 1'b0;

    int send_gap = 0;
    int sink_stall = 0;
    bit send_burst = 1'b0;
    bit sink_burst = 1'b0;

    function automatic void clear_numeral();
        n_digits   = '0;
        n_frac     = '0;
        n_rep      = '0;
        n_group    = '0;
        neg_sign   = 1'b0;
        saw_point  = 1'b0;
        group_open = 1'b0;
        at_start   = 1'b1;
        first_err  = ERR_NONE;
    endfunction

    // Value of a digit character in base 36, or DIGIT_NONE for anything else.
    function automatic int digit_of(input logic [CHAR_W-1:0] c);
        if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
        if (c >= CH_UP_A && c <= CH_UP_Z) return int'(c - CH_UP_A) + 10;
        if (c >= CH_LO_A && c <= CH_LO_Z) return int'(c - CH_LO_A) + 10;
        return DIGIT_NONE;
    endfunction

    // Syntax check of one character while no error is latched yet.
    function automatic void parse_char(input logic [CHAR_W-1:0] c);
        int v;
        v = digit_of(c);
        if (c == CH_MINUS) begin
            if (!at_start) first_err = ERR_SIGN;
            else neg_sign = 1'b1;
        end else if (c == CH_POINT) begin
            if (saw_point) first_err = ERR_TWO_POINTS;
            else if (n_digits == 0) first_err = ERR_NO_INT;
            else saw_point = 1'b1;
        end else if (c == CH_OPEN) begin
            if (group_open) first_err = ERR_NESTED;
            else if (!saw_point) first_err = ERR_RPT_EARLY;
            else begin
                group_open = 1'b1;
                n_group = '0;
            end
        end else if (c == CH_CLOSE) begin
            if (!group_open) first_err = ERR_STRAY_CLOSE;
            else if (n_group == 0) first_err = ERR_EMPTY_RPT;
            else group_open = 1'b0;
        end else if (v < 36 && v < int'(cfg_radix)) begin
            // A digit beyond the store capacity makes the numeral too long.
            if (n_digits >= MAX_DIGITS) begin
                first_err = ERR_TOO_LONG;
            end else begin
                digit_mem[n_digits[ADDR_W-1:0]] = DIGIT_W'(v);
                n_digits++;
                if (saw_point) n_frac++;
                if (group_open) begin
                    n_rep++;
                    n_group++;
                end
            end
        end else begin
            first_err = ERR_BAD_CHAR;
        end
    endfunction

    function automatic void owe_result(input int d, input logic neg, input logic fr,
                                       input logic rp, input logic [ERR_W-1:0] err,
                                       input logic last);
        t_result r;
        r.digit_value = DIGIT_W'(d);
        r.negative    = neg;
        r.in_fraction = fr;
        r.in_repeat   = rp;
        r.error_code  = err;
        r.last_result = last;
        due_results.push_back(r);
    endfunction

    // On the final character: the end-of-numeral checks, then the trimmed
    // digit span or the single error / zero beat.
    function automatic void normalize_numeral();
        logic [ERR_W-1:0] err;
        int len, frac, rep, ipos, first, last, n, dstart;
        err = first_err;
        if (err == ERR_NONE) begin
            if (group_open) err = ERR_UNCLOSED;
            else if (saw_point && n_frac == 0) err = ERR_NO_FRAC;
            else if (n_digits == 0) err = ERR_NO_DIGITS;
        end
        if (err != ERR_NONE) begin
            owe_result(0, 1'b0, 1'b0, 1'b0, err, 1'b1);
            return;
        end
        len  = int'(n_digits);
        frac = int'(n_frac);
        rep  = int'(n_rep);
        ipos = len - frac;
        // Leading integer zeros go, but one stays in front of a point.
        first = 0;
        while (first < ipos && digit_mem[first] == 0) first++;
        if (first == ipos && frac > 0) first = ipos - 1;
        // Trailing fraction zeros go only when nothing repeats.
        last = len - 1;
        if (frac > 0 && rep == 0) begin
            while (last >= ipos && digit_mem[last] == 0) last--;
            if (last < ipos) begin
                frac = 0;
                last = ipos - 1;
            end
        end
        n = (last + 1 > first) ? last + 1 - first : 0;
        if (n == 0 || (n == 1 && digit_mem[first] == 0)) begin
            owe_result(0, 1'b0, 1'b0, 1'b0, ERR_NONE, 1'b1);
            return;
        end
        dstart = ipos - first;
        if (frac > 0) frac = n - dstart;
        if (rep > 0 && n - rep < dstart) rep = 0;
        for (int k = 0; k < n; k++) begin
            owe_result(digit_mem[first + k], neg_sign, k >= n - frac, k >= n - rep,
                       ERR_NONE, k == n - 1);
        end
    endfunction

    function automatic void predict_char(input t_char_beat beat);
        // Once an error is latched the rest of the numeral is ignored.
        if (first_err == ERR_NONE) parse_char(beat.code);
        at_start = 1'b0;
        if (beat.fin) begin
            normalize_numeral();
            clear_numeral();
        end
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fault_count++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Monitor. Result beats are checked before the input beat of the same
    // edge is predicted; a result can never stem from a character that is
    // taken at the very same edge, so this order is always safe.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : watch_beats
        t_result got;
        t_result want;
        t_char_beat taken;
        in_taken  <= i_in_valid && o_in_ready;
        out_taken <= o_out_valid && i_out_ready;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got.digit_value = o_digit_value;
                got.negative    = o_negative;
                got.in_fraction = o_in_fraction;
                got.in_repeat   = o_in_repeat;
                got.error_code  = o_error_code;
                got.last_result = o_last_result;
                if (due_results.size() == 0) begin
                    $error("result beat with no result expected (digit %0d, error %0d)",
                           o_digit_value, o_error_code);
                    fault_count++;
                end else begin
                    want = due_results.pop_front();
                    check_field("digit_value", want.digit_value, got.digit_value);
                    check_field("negative", want.negative, got.negative);
                    check_field("in_fraction", want.in_fraction, got.in_fraction);
                    check_field("in_repeat", want.in_repeat, got.in_repeat);
                    check_field("error_code", want.error_code, got.error_code);
                    check_field("last_result", want.last_result, got.last_result);
                end
            end
            if (i_in_valid && o_in_ready) begin
                taken.code = i_char_code;
                taken.fin  = i_is_final;
                predict_char(taken);
            end
        end
    end

    // Wait drawn per beat. Now and then a side flips into a burst stretch
    // where it does not idle at all.
    function automatic int draw_wait(inout bit burst);
        if ($urandom_range(0, 15) == 0) burst = !burst;
        return burst ? 0 : $urandom_range(0, 13);
    endfunction

    // ------------------------------------------------------------------------
    // Character driver. Valid is computed once per falling edge so that it is
    // never lowered and raised again within one time step.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : drive_chars
        logic nxt_valid;
        t_char_beat beat;
        nxt_valid = i_in_valid;
        if (i_rst_n) begin
            if (i_in_valid && in_taken) nxt_valid = 1'b0;
            if (!nxt_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (char_backlog.size() != 0) begin
                    beat = char_backlog.pop_front();
                    i_char_code <= beat.code;
                    i_is_final  <= beat.fin;
                    nxt_valid = 1'b1;
                    send_gap = draw_wait(send_burst);
                end
            end
        end
        i_in_valid <= nxt_valid;
    end

    // Result sink: after each taken beat it holds ready low for a drawn stall.
    always @(negedge i_clk) begin : drive_ready
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (out_taken) sink_stall = draw_wait(sink_burst);
            if (sink_stall > 0) begin
                sink_stall--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    function automatic void push_char(input logic [CHAR_W-1:0] code, input logic fin);
        t_char_beat beat;
        beat.code = code;
        beat.fin  = fin;
        char_backlog.push_back(beat);
        chars_pushed++;
    endfunction

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_char(s[i], i == s.len() - 1);
    endfunction

    // A digit character that is valid under the current radix; letters come
    // in either case. With a radix of zero every digit is rejected anyway.
    function automatic logic [CHAR_W-1:0] digit_char(input int zero_pct);
        int top, v;
        top = (cfg_radix == 0 || cfg_radix > 36) ? 35 : int'(cfg_radix) - 1;
        v = ($urandom_range(0, 99) < zero_pct) ? 0 : $urandom_range(0, top);
        if (v < 10) return CHAR_W'(CH_0 + v);
        return CHAR_W'(($urandom_range(0, 1) ? CH_UP_A : CH_LO_A) + v - 10);
    endfunction

    // Builds one numeral. Most are well formed with random content: sign,
    // integer digits, point, plain fraction digits and repeating groups. One
    // in ten is a broken numeral with a symbol or a random byte dropped into
    // it, and one in ten is plain noise. A fixed length gives a bare integer
    // of exactly that many digits.
    function automatic void add_numeral(input int fixed_len);
        logic [CHAR_W-1:0] text [$];
        logic [CHAR_W-1:0] symbols [4];
        int kind, int_len, plain_len, zero_pct, pos;
        symbols = '{CH_MINUS, CH_POINT, CH_OPEN, CH_CLOSE};
        kind = (fixed_len > 0) ? 9 : $urandom_range(0, 9);
        zero_pct = $urandom_range(0, 60);
        if (kind == 0) begin
            repeat ($urandom_range(1, 6)) text.push_back(CHAR_W'($urandom_range(0, 255)));
        end else if (fixed_len > 0) begin
            repeat (fixed_len) text.push_back(digit_char(0));
        end else begin
            if ($urandom_range(0, 1)) text.push_back(CH_MINUS);
            // Now and then a long numeral runs up to and past the store size.
            int_len = ($urandom_range(0, 19) == 0) ? $urandom_range(58, 66)
                                                    : $urandom_range(1, 4);
            repeat (int_len) text.push_back(digit_char(zero_pct));
            if ($urandom_range(0, 9) < 7) begin
                text.push_back(CH_POINT);
                plain_len = $urandom_range(0, 3);
                repeat (plain_len) text.push_back(digit_char(zero_pct));
                if (plain_len == 0 || $urandom_range(0, 1)) begin
                    repeat ($urandom_range(1, 2)) begin
                        text.push_back(CH_OPEN);
                        repeat ($urandom_range(1, 3)) text.push_back(digit_char(zero_pct));
                        text.push_back(CH_CLOSE);
                        repeat ($urandom_range(0, 1)) text.push_back(digit_char(zero_pct));
                    end
                end
            end
            if (kind == 1) begin
                pos = $urandom_range(0, text.size() - 1);
                if ($urandom_range(0, 1)) text[pos] = symbols[$urandom_range(0, 3)];
                else text[pos] = CHAR_W'($urandom_range(0, 255));
            end
        end
        for (int i = 0; i < text.size(); i++) push_char(text[i], i == text.size() - 1);
    endfunction

    // Blocks until every character is sent and every owed result has come,
    // then lets the unit settle.
    task automatic wait_idle();
        while (char_backlog.size() != 0 || i_in_valid || due_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // APB write of the radix register, then a read back of it. Upper data
    // bits are random; only the low bits of the register exist.
    task automatic set_radix(input logic [RADIX_W-1:0] value);
        logic [APB_DW-1:0] rd;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= RADIX_ADDR;
        pwdata  <= ($urandom() & ~APB_DW'(6'h3F)) | APB_DW'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        cfg_radix = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rd = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        check_field("radix read back", value, rd[RADIX_W-1:0]);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin : run_test
        int radix_plan [10];
        int phase_start;
        radix_plan = '{2, 36, 16, 0, 1, 63, 37, 10, 8, 0};
        radix_plan[9] = $urandom_range(3, 35);
        clear_numeral();

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed numerals at the reset radix of ten: every error code that
        // short strings can reach, a negative zero, a zero repeating tail, and
        // the character codes at both ends of the range.
        push_text("-0");
        push_text("1-");
        push_text("1..");
        push_text(".");
        push_text("1.((");
        push_text("1(");
        push_text(")");
        push_text("1.()");
        push_char(8'h00, 1'b1);
        push_char(8'hFF, 1'b1);
        push_text("1.(2");
        push_text("1.");
        push_text("-");
        push_text("0.(0)");
        wait_idle();

        // Random numerals, one phase per radix setting. Each phase ends with
        // the sender held back until the unit has delivered everything.
        foreach (radix_plan[p]) begin
            set_radix(RADIX_W'(radix_plan[p]));
            phase_start = chars_pushed;
            // At full base 36: a numeral that exactly fills the digit store
            // and one that overflows it by a single digit.
            if (radix_plan[p] == 36) begin
                add_numeral(MAX_DIGITS);
                add_numeral(MAX_DIGITS + 1);
            end
            while (chars_pushed - phase_start < 8) add_numeral(0);
            wait_idle();
        end

        repeat (20) @(posedge i_clk);
        if (due_results.size() != 0) begin
            $error("%0d result beats never arrived", due_results.size());
            fault_count++;
        end
        if (fault_count == 0) begin
            $display("radix_numeral_parse_normalize_unit regression: pass");
        end else begin
            $display("radix_numeral_parse_normalize_unit regression: fail");
        end
        $finish;
    end

    // Run time limit, far above the slowest legal run of this stimulus.
    initial begin : watchdog
        #4_000_000;
        $display("radix_numeral_parse_normalize_unit regression: fail");
        $finish;
    end

endmodule
